// File: src/resfb_pkg.sv
// Shared types and constants for the resonator filter bank.
// Used by every module of the block; depends on nothing else.
package resfb_pkg;

  // Fixed field widths of the ports.
  localparam int unsigned COEF_W       = 24;
  localparam int unsigned COEF_FRAC    = 22;
  localparam int unsigned BAND_FIELD_W = 6;
  localparam int unsigned CHAN_FIELD_W = 3;
  localparam int unsigned FILT_W       = 24;
  localparam int unsigned CFG_W        = 7;

  // Reset value of the band count register.
  localparam logic [CFG_W-1:0] BANDS_RESET = 7'd16;

  // Input beat commands.
  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  // Control of one multiply-accumulate step.
  typedef struct packed {
    logic valid;  // a product enters this cycle
    logic clr;    // start a new sum with this product
    logic sub;    // subtract the product instead of adding it
  } mac_ctl_t;

endpackage

// File: src/resfb_mac.sv
// Shared multiply-accumulate unit: one registered product, then the running sum.
// Depends on resfb_pkg for the coefficient width and the control struct.
module resfb_mac
  import resfb_pkg::*;
#(
  parameter int unsigned OP_W = 24,
  localparam int unsigned PROD_W = OP_W + COEF_W,
  localparam int unsigned ACC_W = OP_W + COEF_W + 2
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mac_ctl_t                 ctl_i,
  input  logic signed [COEF_W-1:0] coef_i,
  input  logic signed [OP_W-1:0]   op_i,
  output logic signed [ACC_W-1:0]  acc_o
);

  mac_ctl_t                  pctl_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q, acc_d, base, prod_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pctl_q <= '0;
    end else begin
      pctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= coef_i * op_i;
    acc_q  <= acc_d;
  end

  always_comb begin
    base     = pctl_q.clr ? '0 : acc_q;
    prod_ext = ACC_W'(prod_q);
    acc_d    = acc_q;
    if (pctl_q.valid) begin
      acc_d = pctl_q.sub ? (base - prod_ext) : (base + prod_ext);
    end
  end

  assign acc_o = acc_q;

endmodule

// File: src/resfb_round.sv
// Rounds the accumulator to sample precision (half up) and saturates it.
// Depends on resfb_pkg for the coefficient fraction width.
module resfb_round
  import resfb_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 24,
  localparam int unsigned ACC_W = SAMPLE_BITS + COEF_W + 2,
  localparam int unsigned R_W = ACC_W + 1 - COEF_FRAC
) (
  input  logic signed [ACC_W-1:0]       acc_i,
  output logic signed [SAMPLE_BITS-1:0] y_o
);

  localparam logic signed [ACC_W:0] RND = (ACC_W+1)'(1) << (COEF_FRAC - 1);

  logic signed [ACC_W:0] biased;
  logic        [R_W-1:0] r;
  logic                  neg;
  logic                  ovf;

  always_comb begin
    biased = (ACC_W+1)'(acc_i) + RND;
    r      = biased[ACC_W:COEF_FRAC];
    neg    = r[R_W-1];
    // The value fits when every bit above the sample sign bit copies it.
    ovf    = (r[R_W-1:SAMPLE_BITS-1] != {(R_W-SAMPLE_BITS+1){neg}});
    if (ovf) begin
      y_o = {neg, {(SAMPLE_BITS-1){~neg}}};
    end else begin
      y_o = r[SAMPLE_BITS-1:0];
    end
  end

endmodule

// File: src/resonator_filter_bank.sv
// Resonator filter bank top level: sequencer, coefficient and history memories.
// A load beat writes its coefficient when it is accepted. A sample beat runs
// the band steps once per band in use, and a stalled output holds back each
// result; one shared multiplier and the single coefficient read port set this
// pace. After reset the block clears the output history, BANK_SIZE * 2**CH_W
// rows (32 by default), and accepts no input beat until that pass ends.
module resonator_filter_bank
  import resfb_pkg::*;
#(
  parameter int unsigned BANK_SIZE     = 16,
  parameter int unsigned CHANNEL_COUNT = 2,
  parameter int unsigned SAMPLE_BITS   = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration: band count register
  input  logic                        cfg_we_i,
  input  logic [CFG_W-1:0]            cfg_wdata_i,
  // Input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        command_i,
  input  logic [CHAN_FIELD_W-1:0]     channel_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic [BAND_FIELD_W-1:0]     band_index_i,
  input  logic [1:0]                  coef_select_i,
  input  logic signed [COEF_W-1:0]    coef_value_i,
  // Output channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [BAND_FIELD_W-1:0]     band_o,
  output logic [CHAN_FIELD_W-1:0]     out_channel_o,
  output logic signed [FILT_W-1:0]    filtered_o,
  output logic                        last_o
);

  // Derived sizes. The history memory holds one row per band and channel slot,
  // each row packing y[n-2] above y[n-1].
  localparam int unsigned BAND_W     = $clog2(BANK_SIZE);
  localparam int unsigned CH_W       = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int unsigned COEF_AW    = BAND_W + 2;
  localparam int unsigned COEF_DEPTH = BANK_SIZE * 4;
  localparam int unsigned HIST_AW    = BAND_W + CH_W;
  localparam int unsigned HIST_DEPTH = BANK_SIZE << CH_W;
  localparam int unsigned ACC_W      = SAMPLE_BITS + COEF_W + 2;
  localparam int unsigned CHK_CH_W   = CHAN_FIELD_W + 1;
  localparam int unsigned CHK_BAND_W = BAND_FIELD_W + 1;

  // Sequencer states.
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_BAND  = 2'd2;

  // Steps within one band. The coefficient memory is read in steps 0 to 3,
  // products enter the multiplier in steps 1 to 4, the sum settles in step 5
  // and the rounded result leaves in step 6.
  localparam logic [2:0] PH_ISSUE = 3'd0;
  localparam logic [2:0] PH_B0    = 3'd1;
  localparam logic [2:0] PH_B2    = 3'd2;
  localparam logic [2:0] PH_C1    = 3'd3;
  localparam logic [2:0] PH_C2    = 3'd4;
  localparam logic [2:0] PH_SUM   = 3'd5;
  localparam logic [2:0] PH_OUT   = 3'd6;

  logic [1:0]               state_q;
  logic [2:0]               phase_q;
  logic [BAND_W-1:0]        band_q;
  logic [HIST_AW-1:0]       clr_addr_q;
  logic [CFG_W-1:0]         bands_q;
  logic [BAND_W-1:0]        last_band;

  // Per-item payload, held for the whole sample.
  logic [CH_W-1:0]               ch_q;
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [SAMPLE_BITS-1:0] xm2_q;

  // Input history per channel, cleared at reset.
  logic signed [SAMPLE_BITS-1:0] xh1_q [CHANNEL_COUNT];
  logic signed [SAMPLE_BITS-1:0] xh2_q [CHANNEL_COUNT];

  // Output register.
  logic                          out_valid_q;
  logic [BAND_W-1:0]             out_band_q;
  logic [CH_W-1:0]               out_ch_q;
  logic signed [SAMPLE_BITS-1:0] out_filt_q;
  logic                          out_last_q;

  // Memories.
  logic signed [COEF_W-1:0]      coef_mem [COEF_DEPTH];
  logic signed [COEF_W-1:0]      coef_rd_q;
  logic [2*SAMPLE_BITS-1:0]      hist_mem [HIST_DEPTH];
  logic [2*SAMPLE_BITS-1:0]      hist_rd_q;

  logic                          in_fire;
  logic                          ch_ok;
  logic                          band_ok;
  logic                          start;
  logic                          coef_we;
  logic [COEF_AW-1:0]            coef_waddr;
  logic [COEF_AW-1:0]            coef_raddr;
  logic [HIST_AW-1:0]            hist_addr;
  logic                          hist_we;
  logic [HIST_AW-1:0]            hist_waddr;
  logic [2*SAMPLE_BITS-1:0]      hist_wdata;
  logic [CH_W-1:0]               ch_idx;
  logic                          out_free;
  logic                          res_fire;
  logic                          clr_done;
  mac_ctl_t                      mac_ctl;
  logic signed [SAMPLE_BITS-1:0] mac_op;
  logic signed [ACC_W-1:0]       acc;
  logic signed [SAMPLE_BITS-1:0] y_new;
  logic signed [SAMPLE_BITS-1:0] y1;
  logic signed [SAMPLE_BITS-1:0] y2;

  // ---------------------------------------------------------------------------
  // Handshake and input decode
  // ---------------------------------------------------------------------------

  // The block takes a beat only while idle; the clearing pass and every band
  // of a sample hold the input off.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign ch_idx     = channel_i[CH_W-1:0];
  assign ch_ok      = (CHK_CH_W'(channel_i) < CHK_CH_W'(CHANNEL_COUNT));
  assign band_ok    = (CHK_BAND_W'(band_index_i) < CHK_BAND_W'(BANK_SIZE));

  // Samples on a channel that does not exist are dropped without a trace.
  assign start      = in_fire && (command_i == CMD_FILTER) && ch_ok;
  assign coef_we    = in_fire && (command_i == CMD_LOAD) && band_ok;
  assign coef_waddr = {band_index_i[BAND_W-1:0], coef_select_i};

  // A count of zero acts as one band, and a count above the bank size acts as
  // the whole bank.
  always_comb begin
    if (bands_q == '0) begin
      last_band = '0;
    end else if (bands_q > CFG_W'(BANK_SIZE)) begin
      last_band = BAND_W'(BANK_SIZE - 1);
    end else begin
      last_band = BAND_W'(bands_q - CFG_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bands_q <= BANDS_RESET;
    end else if (cfg_we_i) begin
      bands_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------

  assign out_free = !out_valid_q || !out_stall_i;
  assign res_fire = (state_q == ST_BAND) && (phase_q == PH_OUT) && out_free;
  assign clr_done = (clr_addr_q == HIST_AW'(HIST_DEPTH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      phase_q    <= PH_ISSUE;
      band_q     <= '0;
      clr_addr_q <= '0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + HIST_AW'(1);
          if (clr_done) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_BAND;
            phase_q <= PH_ISSUE;
            band_q  <= '0;
          end
        end
        ST_BAND: begin
          if (phase_q != PH_OUT) begin
            phase_q <= phase_q + 3'd1;
          end else if (out_free) begin
            // The result leaves this cycle; move on or finish the sample.
            phase_q <= PH_ISSUE;
            if (band_q == last_band) begin
              state_q <= ST_IDLE;
            end else begin
              band_q <= band_q + BAND_W'(1);
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // The sample and its x[n-2] are captured at acceptance, so the input
  // history can move on at once.
  always_ff @(posedge clk_i) begin
    if (start) begin
      ch_q  <= ch_idx;
      x_q   <= sample_i;
      xm2_q <= xh2_q[ch_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        xh1_q[i] <= '0;
        xh2_q[i] <= '0;
      end
    end else if (start) begin
      xh2_q[ch_idx] <= xh1_q[ch_idx];
      xh1_q[ch_idx] <= sample_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Coefficient memory: one write port for load beats, one registered read.
  // ---------------------------------------------------------------------------

  assign coef_raddr = {band_q, phase_q[1:0]};

  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= coef_value_i;
    end
    coef_rd_q <= coef_mem[coef_raddr];
  end

  // ---------------------------------------------------------------------------
  // Output history memory. The clearing pass and result write-back share the
  // single write port; they never overlap in time.
  // ---------------------------------------------------------------------------

  assign hist_addr  = {band_q, ch_q};
  assign y1         = hist_rd_q[SAMPLE_BITS-1:0];
  assign y2         = hist_rd_q[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign hist_we    = (state_q == ST_CLEAR) || res_fire;
  assign hist_waddr = (state_q == ST_CLEAR) ? clr_addr_q : hist_addr;
  assign hist_wdata = (state_q == ST_CLEAR) ? '0 : {y1, y_new};

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    hist_rd_q <= hist_mem[hist_addr];
  end

  // ---------------------------------------------------------------------------
  // Shared multiply-accumulate and rounding
  // ---------------------------------------------------------------------------

  always_comb begin
    mac_ctl.valid = (state_q == ST_BAND) && (phase_q >= PH_B0) && (phase_q <= PH_C2);
    mac_ctl.clr   = (phase_q == PH_B0);
    mac_ctl.sub   = (phase_q == PH_B2);
    case (phase_q)
      PH_B0:   mac_op = x_q;
      PH_B2:   mac_op = xm2_q;
      PH_C1:   mac_op = y1;
      default: mac_op = y2;
    endcase
  end

  resfb_mac #(
    .OP_W (SAMPLE_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .coef_i (coef_rd_q),
    .op_i   (mac_op),
    .acc_o  (acc)
  );

  resfb_round #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_round (
    .acc_i (acc),
    .y_o   (y_new)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      out_band_q <= band_q;
      out_ch_q   <= ch_q;
      out_filt_q <= y_new;
      out_last_q <= (band_q == last_band);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign band_o        = BAND_FIELD_W'(out_band_q);
  assign out_channel_o = CHAN_FIELD_W'(out_ch_q);
  assign filtered_o    = FILT_W'(out_filt_q);
  assign last_o        = out_last_q;

endmodule
